>>> rtl/core/khts_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the hash-tag slot unit.
// No dependencies; every other file of the unit imports this package.
`timescale 1ns / 1ps

package khts_pkg;

  // Brace characters that open and close the hash tag.
  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;

  // CRC-32 IEEE, reflected form.
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

  // Slot mask value after reset.
  localparam logic [31:0] SLOT_MASK_RESET = 32'h0000_3FFF;

  // Tag search phase, one-hot.
  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_INSIDE = 3'b010,
    PH_CLOSED = 3'b100
  } tag_phase_t;

  // One key item.
  typedef struct packed {
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       last_byte;
  } key_item_t;

  // One result item.
  typedef struct packed {
    logic [31:0] slot;
    logic [31:0] crc_value;
    logic        has_tag;
  } slot_result_t;

  // Folds one byte into a running reflected CRC-32, one bit per step.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'h000000, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/khts_scan.sv
// Per-key scanner: brace tracking and the two running CRC-32 registers.
// Depends on khts_pkg for the item/result types and the CRC byte update.
`timescale 1ns / 1ps

module khts_scan import khts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  key_item_t    item,
  input  logic [31:0]  slot_mask,
  output logic         res_valid,
  output slot_result_t res
);

  tag_phase_t  phase;
  tag_phase_t  phase_next;
  logic [31:0] crc_whole;
  logic [31:0] crc_whole_next;
  logic [31:0] crc_tag;
  logic [31:0] crc_tag_next;
  logic [31:0] crc_sel;

  // Fold the current byte into the key CRC (and, inside a tag, the tag CRC) and advance the tag search.
  always_comb begin
    phase_next     = phase;
    crc_whole_next = crc_whole;
    crc_tag_next   = crc_tag;
    if (item.byte_valid) begin
      crc_whole_next = crc32_byte(crc_whole, item.key_byte);
      unique case (phase)
        PH_SEARCH: begin
          if (item.key_byte == OPEN_BRACE) begin
            phase_next = PH_INSIDE;
          end
        end
        PH_INSIDE: begin
          if (item.key_byte == CLOSE_BRACE) begin
            phase_next = PH_CLOSED;
          end else begin
            crc_tag_next = crc32_byte(crc_tag, item.key_byte);
          end
        end
        PH_CLOSED: begin
          phase_next = PH_CLOSED;
        end
        default: begin
          phase_next = PH_CLOSED;
        end
      endcase
    end
  end

  // Result for a key that ends with this item.
  always_comb begin
    res.has_tag   = (phase_next == PH_CLOSED);
    crc_sel       = res.has_tag ? crc_tag_next : crc_whole_next;
    res.crc_value = crc_sel ^ CRC_XOROUT;
    res.slot      = res.crc_value & slot_mask;
    res_valid     = step && item.last_byte;
  end

  // Running state; the end of a key brings it back to the start value.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEARCH;
      crc_whole <= CRC_INIT;
      crc_tag   <= CRC_INIT;
    end else if (step) begin
      if (item.last_byte) begin
        phase     <= PH_SEARCH;
        crc_whole <= CRC_INIT;
        crc_tag   <= CRC_INIT;
      end else begin
        phase     <= phase_next;
        crc_whole <= crc_whole_next;
        crc_tag   <= crc_tag_next;
      end
    end
  end

  // A finished key leaves the scanner ready for a fresh one.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> phase == PH_SEARCH && crc_whole == CRC_INIT &&
                               crc_tag == CRC_INIT)
    else $error("scanner state not cleared after the last byte");

  // Without a step nothing moves.
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(crc_whole) && $stable(crc_tag) && $stable(phase))
    else $error("scanner state changed without a step");

  // Apart from the reload at the end of a key, the tag CRC only moves while inside an open tag.
  a_tag_crc_inside: assert property (@(posedge clk) disable iff (rst)
    step && !item.last_byte && phase != PH_INSIDE |=> $stable(crc_tag))
    else $error("tag CRC changed outside the tag");

endmodule

>>> rtl/core/khts_out.sv
// Result register toward the output channel, loaded by the scanner.
// Depends on khts_pkg for the result type.
`timescale 1ns / 1ps

module khts_out import khts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  slot_result_t load_data,
  output logic         free,
  output logic         out_valid,
  input  logic         out_ready,
  output slot_result_t out_data
);

  // The register can take a new result when empty or when its content leaves now.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_data <= load_data;
    end
  end

endmodule

>>> rtl/core/key_hash_tag_slot_unit.sv
// Top level of the hash-tag slot unit: input register, scanner, result register.
// Depends on khts_pkg, khts_scan and khts_out.
// A key's last item stalls in the input register while the result register is full.
// Throughput: one item per cycle while not stalled, set by the byte-wide CRC update.
// Reset (rst, synchronous): both stages empty, tag search restarted, slot_mask 0x3FFF.
`timescale 1ns / 1ps

module key_hash_tag_slot_unit import khts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  key_item_t    in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output slot_result_t out_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  logic         s0_valid;
  key_item_t    s0_item;
  logic         s0_adv;
  logic         res_valid;
  slot_result_t res;
  logic         out_free;
  logic [31:0]  slot_mask;

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_mask <= SLOT_MASK_RESET;
    end else if (cfg_valid) begin
      slot_mask <= cfg_data;
    end
  end

  // The held item moves on unless it ends a key and the result register is full.
  assign s0_adv   = s0_valid && (!s0_item.last_byte || out_free);
  assign in_ready = !s0_valid || s0_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_item <= in_data;
    end
  end

  khts_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (s0_adv),
    .item      (s0_item),
    .slot_mask (slot_mask),
    .res_valid (res_valid),
    .res       (res)
  );

  khts_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A result is only produced when the result register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result produced while the result register is full");

  // A stalled item stays in the input register unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s0_valid && !s0_adv |=> s0_valid && $stable(s0_item))
    else $error("stalled input item was lost or changed");

endmodule

>>> tb/key_hash_tag_slot_unit_tb.sv
// Self-checking testbench for key_hash_tag_slot_unit: streams keys byte by byte, predicts
// each key's CRC-32, has-tag flag and slot, and compares every result transfer.
// Depends on khts_pkg and the key_hash_tag_slot_unit RTL.
`timescale 1ns / 1ps

module key_hash_tag_slot_unit_tb;
  import khts_pkg::*;

  localparam int  HOLD_CYCLES    = 400;
  localparam int  PHASE_ITEMS    = 325;
  localparam time RUN_LIMIT      = 2ms;

  // Predicts the unit's results and holds the ones still awaited.
  class slot_board;
    logic [31:0]  mask;
    tag_phase_t   phase;
    logic [31:0]  crc_all;
    logic [31:0]  crc_in_tag;
    slot_result_t awaited_q[$];
    int           errors;

    function new();
      mask   = SLOT_MASK_RESET;
      errors = 0;
      clear_key();
    endfunction

    function void clear_key();
      phase      = PH_SEARCH;
      crc_all    = CRC_INIT;
      crc_in_tag = CRC_INIT;
    endfunction

    function void set_mask(logic [31:0] m);
      mask = m;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    // Bit-serial reflected CRC-32: data bits enter least significant first.
    function logic [31:0] fold_byte(logic [31:0] acc, logic [7:0] b);
      logic [31:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
        if (r[0] ^ b[i]) begin
          r = (r >> 1) ^ CRC_POLY;
        end else begin
          r = r >> 1;
        end
      end
      return r;
    endfunction

    // Called for every accepted input transfer.
    function void note_item(key_item_t it);
      slot_result_t res;
      logic [31:0]  crc;
      if (it.byte_valid) begin
        crc_all = fold_byte(crc_all, it.key_byte);
        case (phase)
          PH_SEARCH: begin
            if (it.key_byte == OPEN_BRACE) phase = PH_INSIDE;
          end
          PH_INSIDE: begin
            if (it.key_byte == CLOSE_BRACE) phase = PH_CLOSED;
            else crc_in_tag = fold_byte(crc_in_tag, it.key_byte);
          end
          default: ;
        endcase
      end
      if (it.last_byte) begin
        res.has_tag   = (phase == PH_CLOSED);
        crc           = (res.has_tag ? crc_in_tag : crc_all) ^ CRC_XOROUT;
        res.crc_value = crc;
        res.slot      = crc & mask;
        awaited_q.push_back(res);
        clear_key();
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Called for every accepted result transfer.
    task check_result(slot_result_t got);
      slot_result_t exp_res;
      if (awaited_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited: %h", got));
      end else begin
        exp_res = awaited_q.pop_front();
        if (got.slot !== exp_res.slot)
          report_mismatch($sformatf("slot %h, predicted %h", got.slot, exp_res.slot));
        if (got.crc_value !== exp_res.crc_value)
          report_mismatch($sformatf("crc_value %h, predicted %h",
                                    got.crc_value, exp_res.crc_value));
        if (got.has_tag !== exp_res.has_tag)
          report_mismatch($sformatf("has_tag %b, predicted %b",
                                    got.has_tag, exp_res.has_tag));
      end
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_ready;
  key_item_t    in_data;
  logic         out_valid;
  logic         out_ready;
  slot_result_t out_data;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;

  slot_board    board;
  int           burst_left;
  int           counted_items;
  bit           hold_request;

  key_hash_tag_slot_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one item and waits for its transfer; then runs down the burst and may idle between bursts.
  task automatic offer(key_item_t it);
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
    if (it.byte_valid || it.last_byte) counted_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put(logic [7:0] b, bit v, bit l);
    key_item_t it;
    it.key_byte   = b;
    it.byte_valid = v;
    it.last_byte  = l;
    offer(it);
  endtask

  // Braces, zero and all-ones bytes are favored so that tags form often.
  function automatic logic [7:0] pick_key_byte();
    case ($urandom_range(0, 9))
      0, 1:    return OPEN_BRACE;
      2:       return CLOSE_BRACE;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One key of random length and content, with occasional idle items and a late end mark.
  task automatic send_random_key();
    int  len;
    bit  late_end;
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = $urandom_range(9, 24);
      default: len = $urandom_range(1, 8);
    endcase
    late_end = (len == 0) || ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      put(pick_key_byte(), 1'b1, !late_end && (i == len - 1));
    end
    if (late_end) put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Stops offering and waits until every awaited result has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_slot_mask(logic [31:0] m);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_mask(m);
  endtask

  task automatic random_phase(logic [31:0] m);
    int stop_at;
    write_slot_mask(m);
    stop_at = counted_items + PHASE_ITEMS;
    while (counted_items < stop_at) send_random_key();
    wait_idle();
  endtask

  // Receiver: ready pattern changes mode now and then; one long hold-off on request.
  initial begin : rx_ready
    int  mode;
    int  mode_left;
    bit  hold_done;
    out_ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  // Main sequence: reset, directed keys, then random phases under several masks.
  initial begin : main_seq
    board         = new();
    burst_left    = 1;
    counted_items = 0;
    hold_request  = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty key.
    put(8'h00, 1'b0, 1'b1);
    // Empty tag hashes the empty string.
    put(OPEN_BRACE, 1'b1, 1'b0);
    put(CLOSE_BRACE, 1'b1, 1'b1);
    // Zero and all-ones bytes.
    put(8'h00, 1'b1, 1'b0);
    put(8'hFF, 1'b1, 1'b1);
    // Open brace never closed, with an idle item in the middle.
    put(OPEN_BRACE, 1'b1, 1'b0);
    put(8'h61, 1'b1, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(8'h62, 1'b1, 1'b1);
    // A second open brace inside the tag belongs to the tag.
    put(OPEN_BRACE, 1'b1, 1'b0);
    put(OPEN_BRACE, 1'b1, 1'b0);
    put(8'h78, 1'b1, 1'b0);
    put(CLOSE_BRACE, 1'b1, 1'b1);
    // Braces after a closed tag are plain key bytes.
    put(OPEN_BRACE, 1'b1, 1'b0);
    put(8'h74, 1'b1, 1'b0);
    put(CLOSE_BRACE, 1'b1, 1'b0);
    put(CLOSE_BRACE, 1'b1, 1'b0);
    put(OPEN_BRACE, 1'b1, 1'b1);
    // Key ended by an item that carries no byte.
    put(8'h61, 1'b1, 1'b0);
    put(8'h62, 1'b1, 1'b0);
    put(8'hA5, 1'b0, 1'b1);
    // Close brace before any open brace.
    put(CLOSE_BRACE, 1'b1, 1'b0);
    put(OPEN_BRACE, 1'b1, 1'b0);
    put(CLOSE_BRACE, 1'b1, 1'b1);
    wait_idle();

    // The long receiver hold-off falls at the start of the first random phase.
    hold_request = 1'b1;
    random_phase(32'hFFFF_FFFF);
    random_phase(32'h0000_0000);
    random_phase($urandom());
    random_phase((32'h1 << $urandom_range(1, 31)) - 32'h1);

    wait_idle();
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> key_hash_tag_slot_unit.f
rtl/core/khts_pkg.sv
rtl/core/khts_scan.sv
rtl/core/khts_out.sv
rtl/core/key_hash_tag_slot_unit.sv
tb/key_hash_tag_slot_unit_tb.sv
